FILE: hw/rtl/qrs_pkg.sv
`timescale 1ns / 1ps

package qrs_pkg;

    localparam int COEF_BITS_DEF     = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int DISC_BITS         = 34;
    localparam int VALUE_BITS        = 34;
    localparam int KIND_BITS         = 2;
    localparam int LANES             = 2;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_TWO_REAL = 2'd0,
        KIND_DOUBLE   = 2'd1,
        KIND_COMPLEX  = 2'd2,
        KIND_A_ZERO   = 2'd3
    } root_kind_t;

    function automatic int max_i(input int x, input int y);
        return (x > y) ? x : y;
    endfunction

endpackage

FILE: hw/rtl/quadratic_root_solver.sv
`timescale 1ns / 1ps

// Channel  | Handshake           | Payload
// ---------+---------------------+------------------------------------------------
// in       | in_valid / in_stall | coef_a, coef_b, coef_c (COEF_BITS, signed)
// out      | out_valid/out_stall | root_kind, discriminant, first_value,
//          |                     | second_value
//
// One item enters per cycle unless a stalled result holds the pipeline. Most of the
// pipeline is the one-digit-per-stage square root and the one-bit-per-stage divider.
// rst_n clears only the valid bits; payload registers carry no reset.
// A stalled result freezes the whole pipeline; in_stall follows at once, so
// no item is dropped or repeated.
module quadratic_root_solver #(
    parameter int COEF_BITS     = qrs_pkg::COEF_BITS_DEF,
    parameter int FRACTION_BITS = qrs_pkg::FRACTION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [COEF_BITS-1:0]         coef_a,
    input  logic signed [COEF_BITS-1:0]         coef_b,
    input  logic signed [COEF_BITS-1:0]         coef_c,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [qrs_pkg::KIND_BITS-1:0]       root_kind,
    output logic signed [qrs_pkg::DISC_BITS-1:0]  discriminant,
    output logic signed [qrs_pkg::VALUE_BITS-1:0] first_value,
    output logic signed [qrs_pkg::VALUE_BITS-1:0] second_value
);
    import qrs_pkg::*;

    // Width plan
    localparam int PW        = max_i(2 * COEF_BITS + 3, DISC_BITS);
    localparam int NB_W      = COEF_BITS + 1 + FRACTION_BITS;   // -b scaled
    localparam int DEN_W     = COEF_BITS + 1;                   // |2a|
    localparam int ROOT_W    = DISC_BITS / 2 + FRACTION_BITS;
    localparam int NUM_S_W   = max_i(NB_W, ROOT_W + 1) + 1;     // signed numerator
    localparam int NUM_MAG_W = NUM_S_W - 1;
    localparam int QW        = NUM_MAG_W + 1;                   // signed quotient
    localparam int SW        = max_i(QW, VALUE_BITS);
    localparam logic signed [SW-1:0] VHI = SW'((64'd1 << (VALUE_BITS - 1)) - 64'd1);
    localparam logic signed [SW-1:0] VLO = -VHI - SW'(1);

    typedef struct packed {
        root_kind_t            kind;
        logic [DISC_BITS-1:0]  disc;
        logic signed [NB_W-1:0] negb;
        logic [DEN_W-1:0]      den;
        logic                  den_neg;
    } sq_side_t;

    typedef struct packed {
        root_kind_t           kind;
        logic [DISC_BITS-1:0] disc;
        logic [LANES-1:0]     q_neg;
    } dv_side_t;

    logic out_valid_reg;

    // Advance everything unless the held result is refused.
    logic pipe_en;
    assign pipe_en  = !(out_valid_reg && out_stall);
    assign in_stall = !pipe_en;

    // Stage 0: capture the coefficients.
    logic                        v0_reg;
    logic signed [COEF_BITS-1:0] a0_reg, b0_reg, c0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (pipe_en)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            a0_reg <= coef_a;
            b0_reg <= coef_b;
            c0_reg <= coef_c;
        end
    end

    // Stage 1: the two products.
    logic                          v1_reg;
    logic signed [2*COEF_BITS-1:0] bb1_reg, ac1_reg;
    logic signed [COEF_BITS-1:0]   a1_reg, b1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (pipe_en)
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            bb1_reg <= b0_reg * b0_reg;
            ac1_reg <= a0_reg * c0_reg;
            a1_reg  <= a0_reg;
            b1_reg  <= b0_reg;
        end
    end

    // Stage 2: discriminant (kept modulo 2^DISC_BITS), kind, |D|, -b and |2a|.
    logic signed [PW-1:0]   d_wide;
    logic [DISC_BITS-1:0]   disc_w;
    logic [DISC_BITS-1:0]   dmag_w;
    root_kind_t             kind_w;
    logic [COEF_BITS-1:0]   amag_w;
    logic signed [NB_W-1:0] negb_w;

    always_comb
    begin
        d_wide = PW'(bb1_reg) - (PW'(ac1_reg) <<< 2);
        disc_w = d_wide[DISC_BITS-1:0];
        dmag_w = disc_w[DISC_BITS-1] ? (~disc_w + DISC_BITS'(1)) : disc_w;
        if (a1_reg == '0)
            kind_w = KIND_A_ZERO;
        else if (disc_w == '0)
            kind_w = KIND_DOUBLE;
        else if (disc_w[DISC_BITS-1])
            kind_w = KIND_COMPLEX;
        else
            kind_w = KIND_TWO_REAL;
        amag_w = a1_reg[COEF_BITS-1] ? COEF_BITS'(-a1_reg) : COEF_BITS'(a1_reg);
        negb_w = (-NB_W'(b1_reg)) <<< FRACTION_BITS;
    end

    logic                 v2_reg;
    logic [DISC_BITS-1:0] dmag2_reg;
    sq_side_t             sq2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (pipe_en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            dmag2_reg       <= dmag_w;
            sq2_reg.kind    <= kind_w;
            sq2_reg.disc    <= disc_w;
            sq2_reg.negb    <= negb_w;
            sq2_reg.den     <= {amag_w, 1'b0};
            sq2_reg.den_neg <= a1_reg[COEF_BITS-1];
        end
    end

    // Square root pipeline.
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    sq_side_t          sq_out;

    qrs_sqrt_pipe #(
        .MAG_W  (DISC_BITS),
        .FRAC_W (FRACTION_BITS),
        .SIDE_W ($bits(sq_side_t)),
        .ROOT_W (ROOT_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (v2_reg),
        .in_mag    (dmag2_reg),
        .in_side   (sq2_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_out)
    );

    // Stage 3: pick the two numerators by kind.
    logic signed [NUM_S_W-1:0] s_x, nb_x, n1_w, n2_w;

    always_comb
    begin
        s_x  = NUM_S_W'({1'b0, sq_root});
        nb_x = NUM_S_W'(sq_out.negb);
        case (sq_out.kind)
            KIND_TWO_REAL:
            begin
                n1_w = nb_x + s_x;
                n2_w = nb_x - s_x;
            end
            KIND_DOUBLE:
            begin
                n1_w = nb_x;
                n2_w = '0;
            end
            KIND_COMPLEX:
            begin
                n1_w = nb_x;
                n2_w = s_x;
            end
            default:
            begin
                n1_w = '0;
                n2_w = '0;
            end
        endcase
    end

    logic                      v3_reg;
    logic signed [NUM_S_W-1:0] n1_3_reg, n2_3_reg;
    sq_side_t                  sq3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (pipe_en)
            v3_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            n1_3_reg <= n1_w;
            n2_3_reg <= n2_w;
            sq3_reg  <= sq_out;
        end
    end

    // Stage 4: magnitudes and quotient signs.
    logic [NUM_S_W-1:0] m1_w, m2_w;

    always_comb
    begin
        m1_w = n1_3_reg[NUM_S_W-1] ? NUM_S_W'(-n1_3_reg) : NUM_S_W'(n1_3_reg);
        m2_w = n2_3_reg[NUM_S_W-1] ? NUM_S_W'(-n2_3_reg) : NUM_S_W'(n2_3_reg);
    end

    logic                              v4_reg;
    logic [LANES-1:0][NUM_MAG_W-1:0]   num4_reg;
    logic [DEN_W-1:0]                  den4_reg;
    dv_side_t                          dv4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (pipe_en)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            num4_reg[0]   <= m1_w[NUM_MAG_W-1:0];
            num4_reg[1]   <= m2_w[NUM_MAG_W-1:0];
            den4_reg      <= sq3_reg.den;
            dv4_reg.kind  <= sq3_reg.kind;
            dv4_reg.disc  <= sq3_reg.disc;
            dv4_reg.q_neg <= {n2_3_reg[NUM_S_W-1] ^ sq3_reg.den_neg,
                              n1_3_reg[NUM_S_W-1] ^ sq3_reg.den_neg};
        end
    end

    // Divider pipeline, both roots side by side.
    logic                            dv_valid;
    logic [LANES-1:0][NUM_MAG_W-1:0] dv_quo;
    dv_side_t                        dv_out;

    qrs_div_pipe #(
        .NUM_W  (NUM_MAG_W),
        .DEN_W  (DEN_W),
        .SIDE_W ($bits(dv_side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (v4_reg),
        .in_num    (num4_reg),
        .in_den    (den4_reg),
        .in_side   (dv4_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_out)
    );

    // Final stage: apply sign, saturate, zero for a equal to zero.
    logic signed [SW-1:0]         q_x   [LANES];
    logic signed [VALUE_BITS-1:0] q_sat [LANES];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            q_x[l] = dv_out.q_neg[l] ? -SW'({1'b0, dv_quo[l]}) : SW'({1'b0, dv_quo[l]});
            if (dv_out.kind == KIND_A_ZERO)
                q_sat[l] = '0;
            else if (q_x[l] > VHI)
                q_sat[l] = VHI[VALUE_BITS-1:0];
            else if (q_x[l] < VLO)
                q_sat[l] = VLO[VALUE_BITS-1:0];
            else
                q_sat[l] = q_x[l][VALUE_BITS-1:0];
        end
    end

    root_kind_t                   kind_reg;
    logic [DISC_BITS-1:0]         disc_reg;
    logic signed [VALUE_BITS-1:0] first_reg, second_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pipe_en)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            kind_reg   <= dv_out.kind;
            disc_reg   <= dv_out.disc;
            first_reg  <= q_sat[0];
            second_reg <= q_sat[1];
        end
    end

    assign out_valid    = out_valid_reg;
    assign root_kind    = kind_reg;
    assign discriminant = disc_reg;
    assign first_value  = first_reg;
    assign second_value = second_reg;

endmodule

FILE: hw/rtl/qrs_sqrt_pipe.sv
`timescale 1ns / 1ps

// One root digit per stage: floor(sqrt(mag * 2^(2*FRAC_W))).
module qrs_sqrt_pipe #(
    parameter int MAG_W  = 34,
    parameter int FRAC_W = 16,
    parameter int SIDE_W = 8,
    parameter int ROOT_W = MAG_W / 2 + FRAC_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [MAG_W-1:0]  in_mag,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output logic [SIDE_W-1:0] out_side
);
    localparam int STEPS = ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic              v_reg    [1:STEPS];
    logic [MAG_W-1:0]  mag_reg  [1:STEPS];
    logic [ROOT_W-1:0] root_reg [1:STEPS];
    logic [REM_W-1:0]  rem_reg  [1:STEPS];
    logic [SIDE_W-1:0] side_reg [1:STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        localparam int PI = MAG_W / 2 - 1 - k;
        logic              src_v;
        logic [MAG_W-1:0]  src_mag;
        logic [ROOT_W-1:0] src_root;
        logic [REM_W-1:0]  src_rem;
        logic [SIDE_W-1:0] src_side;
        logic [1:0]        pair;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k == 0) begin : g_first
            assign src_v    = in_valid;
            assign src_mag  = in_mag;
            assign src_root = '0;
            assign src_rem  = '0;
            assign src_side = in_side;
        end
        else begin : g_rest
            assign src_v    = v_reg[k];
            assign src_mag  = mag_reg[k];
            assign src_root = root_reg[k];
            assign src_rem  = rem_reg[k];
            assign src_side = side_reg[k];
        end

        if (PI >= 0) begin : g_pair
            assign pair = src_mag[2*PI+1 -: 2];
        end
        else begin : g_zero
            assign pair = 2'b00;
        end

        always_comb
        begin
            rem_sh = {src_rem[REM_W-3:0], pair};
            trial  = {src_root, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {src_root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {src_root[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= src_v;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mag_reg[k+1]  <= src_mag;
                root_reg[k+1] <= root_next;
                rem_reg[k+1]  <= rem_next;
                side_reg[k+1] <= src_side;
            end
        end
    end

    assign out_valid = v_reg[STEPS];
    assign out_root  = root_reg[STEPS];
    assign out_side  = side_reg[STEPS];

endmodule

FILE: hw/rtl/qrs_div_pipe.sv
`timescale 1ns / 1ps

// Restoring unsigned divide, one quotient bit per stage, lanes share the divisor.
module qrs_div_pipe #(
    parameter int NUM_W  = 40,
    parameter int DEN_W  = 17,
    parameter int SIDE_W = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [qrs_pkg::LANES-1:0][NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0]                  in_den,
    input  logic [SIDE_W-1:0]                 in_side,
    output logic                              out_valid,
    output logic [qrs_pkg::LANES-1:0][NUM_W-1:0] out_quo,
    output logic [SIDE_W-1:0]                 out_side
);
    import qrs_pkg::*;

    localparam int STEPS = NUM_W;

    logic                          v_reg    [1:STEPS];
    logic [LANES-1:0][NUM_W-1:0]   num_reg  [1:STEPS];
    logic [LANES-1:0][NUM_W-1:0]   quo_reg  [1:STEPS];
    logic [LANES-1:0][DEN_W-1:0]   rem_reg  [1:STEPS];
    logic [DEN_W-1:0]              den_reg  [1:STEPS];
    logic [SIDE_W-1:0]             side_reg [1:STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        localparam int BI = NUM_W - 1 - k;
        logic                        src_v;
        logic [LANES-1:0][NUM_W-1:0] src_num;
        logic [LANES-1:0][NUM_W-1:0] src_quo;
        logic [LANES-1:0][DEN_W-1:0] src_rem;
        logic [DEN_W-1:0]            src_den;
        logic [SIDE_W-1:0]           src_side;
        logic [LANES-1:0][NUM_W-1:0] quo_next;
        logic [LANES-1:0][DEN_W-1:0] rem_next;

        if (k == 0) begin : g_first
            assign src_v    = in_valid;
            assign src_num  = in_num;
            assign src_quo  = '0;
            assign src_rem  = '0;
            assign src_den  = in_den;
            assign src_side = in_side;
        end
        else begin : g_rest
            assign src_v    = v_reg[k];
            assign src_num  = num_reg[k];
            assign src_quo  = quo_reg[k];
            assign src_rem  = rem_reg[k];
            assign src_den  = den_reg[k];
            assign src_side = side_reg[k];
        end

        always_comb
        begin
            logic [DEN_W:0] rem_sh;
            logic [DEN_W:0] diff;
            for (int l = 0; l < LANES; l++)
            begin
                rem_sh = {src_rem[l], src_num[l][BI]};
                diff   = rem_sh - {1'b0, src_den};
                if (rem_sh >= {1'b0, src_den})
                begin
                    rem_next[l] = diff[DEN_W-1:0];
                    quo_next[l] = {src_quo[l][NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = rem_sh[DEN_W-1:0];
                    quo_next[l] = {src_quo[l][NUM_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= src_v;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[k+1]  <= src_num;
                quo_reg[k+1]  <= quo_next;
                rem_reg[k+1]  <= rem_next;
                den_reg[k+1]  <= src_den;
                side_reg[k+1] <= src_side;
            end
        end
    end

    assign out_valid = v_reg[STEPS];
    assign out_quo   = quo_reg[STEPS];
    assign out_side  = side_reg[STEPS];

endmodule
